FILE: hdl/multi_channel_heartbeat_watchdog_defines.svh
// Assertion macros shared by the checker files.
// Both sample on the rising edge of clk and stay quiet while rst_n is low.
`ifndef MULTI_CHANNEL_HEARTBEAT_WATCHDOG_DEFINES_SVH
`define MULTI_CHANNEL_HEARTBEAT_WATCHDOG_DEFINES_SVH

// Property that must hold at every sampled edge.
`define MCHW_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next.
`define MCHW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/mchw_pkg.sv
`default_nettype none

package mchw_pkg;

    localparam int NUM_COMPONENTS = 16;
    localparam int TIME_BITS      = 32;
    localparam int TIMEOUT_W      = 16;
    localparam int COMP_W         = 4;

    localparam int IDX_W  = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1;
    localparam int SCAN_N = (NUM_COMPONENTS < 16) ? NUM_COMPONENTS : 16;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1000;

    localparam logic [1:0] EV_NEW      = 2'd0;
    localparam logic [1:0] EV_RETURNED = 2'd1;
    localparam logic [1:0] EV_TIMEOUT  = 2'd2;

    localparam logic REQ_HEARTBEAT = 1'b0;
    localparam logic REQ_TICK      = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [COMP_W-1:0] source_id;
    } req_t;

    typedef struct packed {
        logic [1:0]        event_kind;
        logic [COMP_W-1:0] event_component;
        logic              last_event;
    } evt_t;

endpackage

`default_nettype wire

FILE: hdl/mchw_age_unit.sv
`default_nettype none

// Shared elapsed-time check: wrapping difference against the stored stamp,
// then an unsigned strict compare with the timeout.
module mchw_age_unit
    import mchw_pkg::*;
(
    input  wire logic [TIME_BITS-1:0] time_now,
    input  wire logic [TIME_BITS-1:0] stamp,
    input  wire logic [TIMEOUT_W-1:0] timeout,
    output logic                      expired
);

    logic [TIME_BITS-1:0] elapsed;

    always_comb
    begin
        elapsed = time_now - stamp;
        expired = (elapsed > TIME_BITS'(timeout));
    end

endmodule

`default_nettype wire

FILE: hdl/multi_channel_heartbeat_watchdog.sv
// Heartbeat item: ST_HB_READ reads the stamp and ST_HB_EVAL compares it; a new or returned
// result goes into the output register, and the next item is taken after that, longer while
// the result waits on evt_ready. Tick item: one table read and one shared age compare per
// entry for min(NUM_COMPONENTS,16) entries, then n timeout results from ST_EMIT; the next
// item is taken after the last of them, longer while a result waits on evt_ready.
// Reset clears the tracked marks and the time counter and loads the timeout with 1000.
`default_nettype none

module multi_channel_heartbeat_watchdog
    import mchw_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output logic                      req_ready,
    input  wire req_t                 req,
    output logic                      evt_valid,
    input  wire logic                 evt_ready,
    output evt_t                      evt,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [TIMEOUT_W-1:0] cfg_data
);

    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_HB_READ   = 6'b000010,
        ST_HB_EVAL   = 6'b000100,
        ST_SCAN_READ = 6'b001000,
        ST_SCAN_EVAL = 6'b010000,
        ST_EMIT      = 6'b100000
    } state_t;

    localparam logic [IDX_W-1:0] SCAN_LAST = IDX_W'(SCAN_N - 1);

    state_t                 state_reg, state_next;
    logic [TIMEOUT_W-1:0]   timeout_reg;
    logic [TIME_BITS-1:0]   time_reg, time_next;
    logic [NUM_COMPONENTS-1:0] tracked_reg, tracked_next;
    logic [IDX_W-1:0]       id_reg, id_next;
    logic [IDX_W-1:0]       scan_reg, scan_next;
    logic [SCAN_N-1:0]      hit_reg, hit_next;
    logic                   evt_valid_reg, evt_valid_next;
    evt_t                   evt_reg, evt_next;

    logic [TIME_BITS-1:0]   stamp_mem [NUM_COMPONENTS];
    logic [TIME_BITS-1:0]   stamp_reg;
    logic [IDX_W-1:0]       rd_addr;
    logic                   rd_en;
    logic                   wr_en;
    logic                   expired;

    logic                   slot_free;
    logic                   req_fire;
    logic [SCAN_N-1:0]      hit_low;
    logic [SCAN_N-1:0]      hit_rest;
    logic [IDX_W-1:0]       hit_idx;

    mchw_age_unit u_age (
        .time_now (time_reg),
        .stamp    (stamp_reg),
        .timeout  (timeout_reg),
        .expired  (expired)
    );

    assign req_ready = (state_reg == ST_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign cfg_ready = 1'b1;
    assign evt_valid = evt_valid_reg;
    assign evt       = evt_reg;
    assign slot_free = !evt_valid_reg || evt_ready;

    // Lowest pending timeout goes out first, so ids leave in ascending order.
    always_comb
    begin
        hit_low  = hit_reg & (~hit_reg + 1'b1);
        hit_rest = hit_reg & ~hit_low;
        hit_idx  = '0;
        for (int i = 0; i < SCAN_N; i++)
        begin
            if (hit_low[i])
            begin
                hit_idx = hit_idx | IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        time_next      = time_reg;
        tracked_next   = tracked_reg;
        id_next        = id_reg;
        scan_next      = scan_reg;
        hit_next       = hit_reg;
        evt_valid_next = evt_valid_reg;
        evt_next       = evt_reg;
        rd_en          = 1'b0;
        rd_addr        = id_reg;
        wr_en          = 1'b0;

        if (evt_valid_reg && evt_ready)
        begin
            evt_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.req_type == REQ_TICK)
                    begin
                        time_next  = time_reg + 1'b1;
                        scan_next  = '0;
                        hit_next   = '0;
                        state_next = ST_SCAN_READ;
                    end
                    else if (32'(req.source_id) < NUM_COMPONENTS)
                    begin
                        id_next    = IDX_W'(req.source_id);
                        state_next = ST_HB_READ;
                    end
                end
            end
            ST_HB_READ:
            begin
                rd_en      = 1'b1;
                rd_addr    = id_reg;
                state_next = ST_HB_EVAL;
            end
            ST_HB_EVAL:
            begin
                if (!tracked_reg[id_reg] || expired)
                begin
                    // An event must wait for a free output register.
                    if (slot_free)
                    begin
                        evt_valid_next           = 1'b1;
                        evt_next.event_kind      = tracked_reg[id_reg] ? EV_RETURNED
                                                                       : EV_NEW;
                        evt_next.event_component = COMP_W'(id_reg);
                        evt_next.last_event      = 1'b1;
                        wr_en                    = 1'b1;
                        tracked_next[id_reg]     = 1'b1;
                        state_next               = ST_IDLE;
                    end
                end
                else
                begin
                    wr_en      = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN_READ:
            begin
                rd_en      = 1'b1;
                rd_addr    = scan_reg;
                state_next = ST_SCAN_EVAL;
            end
            ST_SCAN_EVAL:
            begin
                if (tracked_reg[scan_reg] && expired)
                begin
                    hit_next[scan_reg]     = 1'b1;
                    tracked_next[scan_reg] = 1'b0;
                end
                if (scan_reg == SCAN_LAST)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    scan_next  = scan_reg + 1'b1;
                    state_next = ST_SCAN_READ;
                end
            end
            ST_EMIT:
            begin
                if (hit_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else if (slot_free)
                begin
                    evt_valid_next           = 1'b1;
                    evt_next.event_kind      = EV_TIMEOUT;
                    evt_next.event_component = COMP_W'(hit_idx);
                    evt_next.last_event      = (hit_rest == '0);
                    hit_next                 = hit_rest;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            timeout_reg   <= TIMEOUT_RESET;
            time_reg      <= '0;
            tracked_reg   <= '0;
            evt_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            time_reg      <= time_next;
            tracked_reg   <= tracked_next;
            evt_valid_reg <= evt_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                timeout_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        scan_reg <= scan_next;
        hit_reg  <= hit_next;
        evt_reg  <= evt_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stamp_mem[id_reg] <= time_reg;
        end
        if (rd_en)
        begin
            stamp_reg <= stamp_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/mchw_checker.sv
`include "multi_channel_heartbeat_watchdog_defines.svh"
`default_nettype none

module mchw_checker
    import mchw_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 req_valid,
    input wire logic                 req_ready,
    input wire logic                 evt_valid,
    input wire logic                 evt_ready,
    input wire evt_t                 evt
);

    logic evt_stall;
    logic req_fire;
    logic hb_evt;
    logic code_ok;

    assign evt_stall = evt_valid && !evt_ready;
    assign req_fire  = req_valid && req_ready;
    assign hb_evt    = evt_valid && (evt.event_kind != EV_TIMEOUT);
    assign code_ok   = (evt.event_kind == EV_NEW) || (evt.event_kind == EV_RETURNED)
                       || (evt.event_kind == EV_TIMEOUT);

    // A stalled item stays on the output unchanged.
    `MCHW_ASSERT_NEXT(a_evt_hold, evt_stall, evt_valid && $stable(evt), "stalled evt changed")

    // Every item keeps the block busy, so req_ready is low in the cycle after an accept.
    `MCHW_ASSERT_NEXT(a_busy_after_req, req_fire, !req_ready, "req_ready high after accept")

    // Heartbeat results are always single, hence always last.
    `MCHW_ASSERT(a_hb_single, !hb_evt || evt.last_event, "heartbeat result not marked last")

    // Only the three defined event codes ever appear.
    `MCHW_ASSERT(a_evt_code, !evt_valid || code_ok, "undefined event code")

endmodule

bind multi_channel_heartbeat_watchdog mchw_checker u_mchw_checker (.*);

`default_nettype wire

FILE: tb/sv/watchdog_event_checker.sv
module watchdog_event_checker
    import mchw_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    input  wire logic                 req_ready,
    input  wire req_t                 req,
    input  wire logic                 evt_valid,
    input  wire logic                 evt_ready,
    input  wire evt_t                 evt,
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic [TIMEOUT_W-1:0] cfg_data,
    output int                        mismatches,
    output int                        outstanding
);

    logic [TIMEOUT_W-1:0]      limit_ticks;
    logic [NUM_COMPONENTS-1:0] alive;
    logic [TIME_BITS-1:0]      beat_time [NUM_COMPONENTS];
    logic [TIME_BITS-1:0]      clock_now;
    evt_t                      due_events [$];
    evt_t                      want;
    int                        bad;

    // The age wraps with the time counter and must strictly exceed the limit.
    function automatic logic stale(int id);
        logic [TIME_BITS-1:0] age;
        age = clock_now - beat_time[id];
        return age > limit_ticks;
    endfunction

    function automatic evt_t make_event(logic [1:0] kind, int id);
        evt_t e;
        e.event_kind      = kind;
        e.event_component = COMP_W'(id);
        e.last_event      = 1'b0;
        return e;
    endfunction

    function automatic void forecast_events(req_t r);
        evt_t found [$];
        evt_t e;
        int   id;
        id = int'(r.source_id);
        if (r.req_type == REQ_HEARTBEAT) begin
            // Ids beyond the table are dropped without a trace.
            if (id < NUM_COMPONENTS) begin
                if (!alive[id])
                    found = {found, make_event(EV_NEW, id)};
                else if (stale(id))
                    found = {found, make_event(EV_RETURNED, id)};
                alive[id]     = 1'b1;
                beat_time[id] = clock_now;
            end
        end
        else begin
            clock_now = clock_now + 1'b1;
            for (int i = 0; i < SCAN_N; i++) begin
                if (alive[i] && stale(i)) begin
                    found = {found, make_event(EV_TIMEOUT, i)};
                    alive[i] = 1'b0;
                end
            end
        end
        foreach (found[k]) begin
            e = found[k];
            e.last_event = (k == found.size() - 1);
            due_events = {due_events, e};
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            limit_ticks = TIMEOUT_RESET;
            alive       = '0;
            clock_now   = '0;
            due_events.delete();
            bad         = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else begin
            if (evt_valid && evt_ready) begin
                if (due_events.size() == 0) begin
                    bad++;
                    if (bad <= 10)
                        $display("unexpected event: kind %0d component %0d last %0d",
                                 evt.event_kind, evt.event_component, evt.last_event);
                end
                else begin
                    want = due_events.pop_front();
                    if (evt.event_kind !== want.event_kind
                        || evt.event_component !== want.event_component
                        || evt.last_event !== want.last_event) begin
                        bad++;
                        if (bad <= 10)
                            $display({"event mismatch: expected kind %0d component %0d ",
                                      "last %0d, got kind %0d component %0d last %0d"},
                                     want.event_kind, want.event_component, want.last_event,
                                     evt.event_kind, evt.event_component, evt.last_event);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                limit_ticks = cfg_data;
            if (req_valid && req_ready)
                forecast_events(req);
            mismatches  <= bad;
            outstanding <= due_events.size();
        end
    end

endmodule

FILE: tb/sv/multi_channel_heartbeat_watchdog_test.sv
module multi_channel_heartbeat_watchdog_test;
    import mchw_pkg::*;

    // A full scan visits every table entry before its events go out, and may still run after its last event.
    localparam int SETTLE_CYCLES = 80;
    localparam int PHASES        = 7;
    localparam int PHASE_ITEMS   = 57;
    localparam logic [TIMEOUT_W-1:0] PHASE_LIMITS [PHASES] =
        '{16'd65535, 16'd3, 16'd0, 16'd12, 16'd1, 16'd6, 16'd2};

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_ready;
    req_t                 req       = '0;
    logic                 evt_valid;
    logic                 evt_ready = 1'b0;
    evt_t                 evt;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [TIMEOUT_W-1:0] cfg_data  = '0;
    int                   send_gap_pct = 13;
    int                   recv_gap_pct = 56;
    int                   mismatches;
    int                   outstanding;

    multi_channel_heartbeat_watchdog uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .evt_valid (evt_valid),
        .evt_ready (evt_ready),
        .evt       (evt),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    watchdog_event_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .evt_valid   (evt_valid),
        .evt_ready   (evt_ready),
        .evt         (evt),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        evt_ready <= ($urandom_range(99) >= recv_gap_pct);
    end

    task automatic send_request(logic kind, logic [COMP_W-1:0] id);
        req_t item;
        item.req_type  = kind;
        item.source_id = id;
        while ($urandom_range(99) < send_gap_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do @(posedge clk); while (!req_ready);
    endtask

    // Holds the sender until every predicted event has come back.
    task automatic drain(int extra);
        req_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_timeout(logic [TIMEOUT_W-1:0] ticks);
        cfg_valid <= 1'b1;
        cfg_data  <= ticks;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        logic kind;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default timeout: a first beat is new, a repeat is silent.
        send_request(REQ_HEARTBEAT, 4'd0);
        send_request(REQ_HEARTBEAT, 4'd0);
        send_request(REQ_TICK, 4'd9);
        drain(SETTLE_CYCLES);

        // Age a component under a huge limit, then shrink the limit so it returns.
        write_timeout(16'hFFFF);
        send_request(REQ_HEARTBEAT, 4'd5);
        send_request(REQ_TICK, 4'd0);
        send_request(REQ_TICK, 4'd15);
        drain(SETTLE_CYCLES);
        write_timeout(16'd1);
        send_request(REQ_HEARTBEAT, 4'd5);
        send_request(REQ_TICK, 4'd0);
        drain(SETTLE_CYCLES);

        // Zero limit with every component tracked: one tick times out all of them.
        write_timeout(16'd0);
        for (int id = 0; id < 16; id++)
            send_request(REQ_HEARTBEAT, COMP_W'(id));
        send_request(REQ_TICK, 4'd0);
        drain(SETTLE_CYCLES);

        for (int p = 0; p < PHASES; p++)
        begin
            if (p < 2)
            begin
                send_gap_pct = 13;
                recv_gap_pct = 56;
            end
            else if (p < 4)
            begin
                send_gap_pct = 56;
                recv_gap_pct = 13;
            end
            else
            begin
                send_gap_pct = 0;
                recv_gap_pct = 0;
            end
            write_timeout(PHASE_LIMITS[p]);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                kind = ($urandom_range(3) == 0) ? REQ_TICK : REQ_HEARTBEAT;
                send_request(kind, COMP_W'($urandom_range(15)));
                if (n == PHASE_ITEMS / 2)
                    drain(0);
            end
            drain(SETTLE_CYCLES);
        end

        if (mismatches == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
